>>> rtl/encoder_counter_and_key_events_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the encoder counter and key event block
// Concurrent checks that drop away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ENCODER_COUNTER_AND_KEY_EVENTS_ASSERT_SVH
`define ENCODER_COUNTER_AND_KEY_EVENTS_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ECKE_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("encoder counter and key events: check failed");
// next-cycle implication
`define ECKE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("encoder counter and key events: check failed");
`else
`define ECKE_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define ECKE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/ecke_pkg.sv
// ----------------------------------------------------------------------------
// ecke_pkg
// Shared types and constants for the encoder counter and key event block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecke_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int NUM_KEYS            = 5;
   localparam int NUM_DIR_KEYS        = 4;
   localparam int CENTRE_KEY          = 4;
   localparam int EVENT_WIDTH         = 15;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int DEBOUNCE_WIDTH      = 7;
   localparam int TICK_WIDTH          = 16;

   // event bit positions
   localparam int EV_INC        = 0;
   localparam int EV_DEC        = 1;
   localparam int EV_MAX        = 2;
   localparam int EV_MIN        = 3;
   localparam int EV_CTR_PUSH   = 4;
   localparam int EV_CTR_RELEASE = 5;
   localparam int EV_CTR_DOUBLE = 6;
   localparam int EV_DIR_BASE   = 7;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_INC  = 2'd1,
      CMD_DEC  = 2'd2,
      CMD_LOAD = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_VALUE_MIN          = 3'd0,
      REG_VALUE_MAX          = 3'd1,
      REG_STEP_SIZE          = 3'd2,
      REG_WRAP_ENABLE        = 3'd3,
      REG_ENC_GUARD_TICKS    = 3'd4,
      REG_KEY_DEBOUNCE_TICKS = 3'd5,
      REG_DOUBLE_PUSH_WINDOW = 3'd6
   } reg_index_type;

   typedef enum logic [5:0] {
      PH_WAIT_PUSH     = 6'b000001,
      PH_WAIT_RELEASE  = 6'b000010,
      PH_WAIT_DPUSH    = 6'b000100,
      PH_WAIT_DRELEASE = 6'b001000,
      PH_TIMEOUT       = 6'b010000,
      PH_PUSH_RESET    = 6'b100000
   } centre_phase_type;

   // configuration reset values; value limits and step as 32-bit register images
   localparam logic [31:0] VALUE_MIN_RESET   = 32'h8000_0000;
   localparam logic [31:0] VALUE_MAX_RESET   = 32'h7FFF_FFFF;
   localparam logic [31:0] STEP_SIZE_RESET   = 32'h0000_0001;
   localparam logic [TICK_WIDTH-1:0] GUARD_TICKS_RESET = 16'd0;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 7'd10;
   localparam logic [TICK_WIDTH-1:0] WINDOW_RESET = 16'd300;

endpackage

>>> rtl/encoder_counter_and_key_events.sv
// ----------------------------------------------------------------------------
// encoder_counter_and_key_events
// Encoder counter with limits, five debounced keys and key event reporting.
// ----------------------------------------------------------------------------
//   Request channel (req_valid / req_stall) carries one command per
//   transaction: a 1 ms tick with the raw key levels, an increment edge,
//   a decrement edge or a counter load. Each request yields exactly one
//   response transaction on rsp_valid / rsp_stall with the event bits, the
//   counter, the debounced key levels and an interrupt flag.
//   The response is registered and appears in the cycle after its request
//   is accepted. Throughput is one transaction per cycle unless stalled; all
//   state is updated by a single pass of logic between the request port and
//   the response register, the widest part being the add and limit compare.
//   While the receiver stalls, the response register holds and req_stall is
//   raised only once that register is full, so one further request is never
//   taken before the waiting response leaves.
//   Reset (synchronous) clears the counter, debounce state and key phases
//   and loads the configuration defaults; no clearing pass is needed.
//   Write the csr_ registers only while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "encoder_counter_and_key_events_assert.svh"

module encoder_counter_and_key_events #(
   parameter int VALUE_WIDTH = ecke_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_cmd,
   input  logic [ecke_pkg::NUM_KEYS-1:0]        req_key_raw,
   input  logic signed [31:0]                   req_load_value,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ecke_pkg::EVENT_WIDTH-1:0]     rsp_events,
   output logic signed [31:0]                   rsp_counter_value,
   output logic [ecke_pkg::NUM_KEYS-1:0]        rsp_key_state,
   output logic                                 rsp_interrupt_request,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [ecke_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ecke_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import ecke_pkg::*;

   localparam int W = VALUE_WIDTH;
   localparam logic [W-1:0] VAL_MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] VAL_MOST_POS = {1'b0, {(W-1){1'b1}}};

   // configuration
   logic [W-1:0]                value_min_ff, value_max_ff, step_size_ff;
   logic                        wrap_enable_ff;
   logic [TICK_WIDTH-1:0]       guard_ticks_ff;
   logic [DEBOUNCE_WIDTH-1:0]   debounce_ticks_ff;
   logic [TICK_WIDTH-1:0]       window_ticks_ff;

   // block state
   logic [W-1:0]                counter_ff, counter_in;
   logic [TICK_WIDTH-1:0]       guard_count_ff, guard_count_in;
   logic                        last_dir_ff, last_dir_in;
   logic [DEBOUNCE_WIDTH-1:0]   key_count_ff [NUM_KEYS];
   logic [DEBOUNCE_WIDTH-1:0]   key_count_in [NUM_KEYS];
   logic [NUM_KEYS-1:0]         key_level_ff, key_level_in;
   centre_phase_type            centre_phase_ff, centre_phase_in;
   logic [TICK_WIDTH-1:0]       window_count_ff, window_count_in;
   logic [NUM_DIR_KEYS-1:0]     dir_phase_ff, dir_phase_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [EVENT_WIDTH-1:0]      rsp_events_ff, events_in;
   logic [31:0]                 rsp_counter_ff;
   logic [NUM_KEYS-1:0]         rsp_keys_ff;
   logic                        rsp_irq_ff;

   logic                        req_accept;
   logic                        rsp_accept;
   cmd_type                     cmd;
   logic                        is_dec;
   logic                        edge_blocked;
   logic signed [W:0]           sum;
   logic signed [W:0]           lo_ext, hi_ext, most_neg_ext, most_pos_ext;
   logic                        ctr;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid_ff & ~rsp_stall;
   assign cmd        = cmd_type'(req_cmd);
   assign is_dec     = (cmd == CMD_DEC);

   // exact sum, one bit wider than the counter
   assign lo_ext       = (W+1)'($signed(value_min_ff));
   assign hi_ext       = (W+1)'($signed(value_max_ff));
   assign most_neg_ext = (W+1)'($signed(VAL_MOST_NEG));
   assign most_pos_ext = (W+1)'($signed(VAL_MOST_POS));
   assign sum = is_dec ? (W+1)'($signed(counter_ff)) - (W+1)'($signed(step_size_ff))
                       : (W+1)'($signed(counter_ff)) + (W+1)'($signed(step_size_ff));
   assign edge_blocked = (last_dir_ff != is_dec) && (guard_count_ff < guard_ticks_ff);

   always_comb begin
      counter_in      = counter_ff;
      guard_count_in  = guard_count_ff;
      last_dir_in     = last_dir_ff;
      key_count_in    = key_count_ff;
      key_level_in    = key_level_ff;
      centre_phase_in = centre_phase_ff;
      window_count_in = window_count_ff;
      dir_phase_in    = dir_phase_ff;
      events_in       = '0;
      ctr             = 1'b0;

      case (cmd)
         CMD_TICK: begin
            if (guard_count_ff < guard_ticks_ff) begin
               guard_count_in = guard_count_ff + 1'b1;
            end
            // debounce every key
            for (int k = 0; k < NUM_KEYS; k++) begin
               if (req_key_raw[k]) begin
                  if (key_count_ff[k] >= debounce_ticks_ff) begin
                     key_count_in[k] = debounce_ticks_ff;
                     key_level_in[k] = 1'b1;
                  end else begin
                     key_count_in[k] = key_count_ff[k] + 1'b1;
                  end
               end else begin
                  if (key_count_ff[k] == '0) begin
                     key_level_in[k] = 1'b0;
                  end else begin
                     key_count_in[k] = key_count_ff[k] - 1'b1;
                  end
               end
            end

            ctr = key_level_in[CENTRE_KEY];
            // window expiry overrides the phase before it is decoded
            if (window_count_ff > window_ticks_ff) begin
               centre_phase_in = PH_TIMEOUT;
            end else begin
               window_count_in = window_count_ff + 1'b1;
            end

            unique case (centre_phase_in)
               PH_WAIT_RELEASE: begin
                  if (!ctr) centre_phase_in = PH_WAIT_DPUSH;
               end
               PH_WAIT_DPUSH: begin
                  if (ctr) centre_phase_in = PH_WAIT_DRELEASE;
               end
               PH_WAIT_DRELEASE: begin
                  if (!ctr) begin
                     window_count_in          = '0;
                     centre_phase_in          = PH_WAIT_PUSH;
                     events_in[EV_CTR_DOUBLE] = 1'b1;
                  end
               end
               PH_TIMEOUT: begin
                  window_count_in        = '0;
                  events_in[EV_CTR_PUSH] = 1'b1;
                  if (ctr) begin
                     centre_phase_in = PH_PUSH_RESET;
                  end else begin
                     centre_phase_in           = PH_WAIT_PUSH;
                     events_in[EV_CTR_RELEASE] = 1'b1;
                  end
               end
               PH_PUSH_RESET: begin
                  window_count_in = '0;
                  if (!ctr) begin
                     centre_phase_in           = PH_WAIT_PUSH;
                     events_in[EV_CTR_RELEASE] = 1'b1;
                  end
               end
               default: begin
                  window_count_in = '0;
                  centre_phase_in = ctr ? PH_WAIT_RELEASE : PH_WAIT_PUSH;
               end
            endcase

            // press and release of the direction keys
            for (int k = 0; k < NUM_DIR_KEYS; k++) begin
               if (!dir_phase_ff[k] && key_level_in[k]) begin
                  dir_phase_in[k]               = 1'b1;
                  events_in[EV_DIR_BASE + 2*k]  = 1'b1;
               end else if (dir_phase_ff[k] && !key_level_in[k]) begin
                  dir_phase_in[k]               = 1'b0;
                  events_in[EV_DIR_BASE + 2*k + 1] = 1'b1;
               end
            end
         end

         CMD_INC, CMD_DEC: begin
            // drop a reversal inside the guard time
            if (!edge_blocked) begin
               guard_count_in = '0;
               last_dir_in    = is_dec;
               if (!is_dec) begin
                  events_in[EV_INC] = 1'b1;
                  if (sum > hi_ext) begin
                     counter_in        = wrap_enable_ff ? value_min_ff : value_max_ff;
                     events_in[EV_MAX] = 1'b1;
                  end else if (sum < most_neg_ext) begin
                     counter_in = VAL_MOST_NEG;
                  end else begin
                     counter_in = sum[W-1:0];
                  end
               end else begin
                  events_in[EV_DEC] = 1'b1;
                  if (sum < lo_ext) begin
                     counter_in        = wrap_enable_ff ? value_max_ff : value_min_ff;
                     events_in[EV_MIN] = 1'b1;
                  end else if (sum > most_pos_ext) begin
                     counter_in = VAL_MOST_POS;
                  end else begin
                     counter_in = sum[W-1:0];
                  end
               end
            end
         end

         default: begin
            counter_in = W'(req_load_value);
         end
      endcase
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_accept);

   // control and block state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         counter_ff      <= '0;
         guard_count_ff  <= '0;
         last_dir_ff     <= 1'b0;
         key_level_ff    <= '0;
         centre_phase_ff <= PH_WAIT_PUSH;
         window_count_ff <= '0;
         dir_phase_ff    <= '0;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_count_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            counter_ff      <= counter_in;
            guard_count_ff  <= guard_count_in;
            last_dir_ff     <= last_dir_in;
            key_count_ff    <= key_count_in;
            key_level_ff    <= key_level_in;
            centre_phase_ff <= centre_phase_in;
            window_count_ff <= window_count_in;
            dir_phase_ff    <= dir_phase_in;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         value_min_ff      <= W'($signed(VALUE_MIN_RESET));
         value_max_ff      <= W'($signed(VALUE_MAX_RESET));
         step_size_ff      <= W'($signed(STEP_SIZE_RESET));
         wrap_enable_ff    <= 1'b0;
         guard_ticks_ff    <= GUARD_TICKS_RESET;
         debounce_ticks_ff <= DEBOUNCE_RESET;
         window_ticks_ff   <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_VALUE_MIN:          value_min_ff      <= W'($signed(csr_write_data));
            REG_VALUE_MAX:          value_max_ff      <= W'($signed(csr_write_data));
            REG_STEP_SIZE:          step_size_ff      <= W'($signed(csr_write_data));
            REG_WRAP_ENABLE:        wrap_enable_ff    <= csr_write_data[0];
            REG_ENC_GUARD_TICKS:    guard_ticks_ff    <= csr_write_data[TICK_WIDTH-1:0];
            REG_KEY_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_write_data[DEBOUNCE_WIDTH-1:0];
            REG_DOUBLE_PUSH_WINDOW: window_ticks_ff   <= csr_write_data[TICK_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // response payload: load on accept, hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_events_ff  <= events_in;
         rsp_counter_ff <= 32'(counter_in);
         rsp_keys_ff    <= key_level_in;
         rsp_irq_ff     <= |events_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_events            = rsp_events_ff;
   assign rsp_counter_value     = $signed(rsp_counter_ff);
   assign rsp_key_state         = rsp_keys_ff;
   assign rsp_interrupt_request = rsp_irq_ff;

   `ECKE_ASSERT_NEXT(a_accept_gives_response, clock, reset, req_accept, rsp_valid_ff)
   `ECKE_ASSERT_HOLDS(a_irq_matches_events, clock, reset, rsp_valid_ff,
                      rsp_irq_ff == (rsp_events_ff != '0))
   `ECKE_ASSERT_HOLDS(a_encoder_key_exclusive, clock, reset,
                      rsp_valid_ff && (rsp_events_ff[EV_DEC:EV_INC] != '0),
                      rsp_events_ff[EVENT_WIDTH-1:EV_CTR_PUSH] == '0)
   `ECKE_ASSERT_HOLDS(a_limit_flag_with_edge, clock, reset,
                      rsp_valid_ff && (rsp_events_ff[EV_MAX] || rsp_events_ff[EV_MIN]),
                      (rsp_events_ff[EV_MAX] == rsp_events_ff[EV_INC]) &&
                      (rsp_events_ff[EV_MIN] == rsp_events_ff[EV_DEC]))

endmodule
